// File: rtl/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants for the piezo hit detector.
// ----------------------------------------------------------------------------
package phd_pkg;

    // fixed field widths of the sample, result and config ports
    localparam int unsigned FIELD_W = 12;
    localparam int unsigned WIN_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // channels that carry a sample on the input port
    localparam int unsigned IN_CH = 2;

    typedef enum logic [2:0] {
        REG_TRIGGER  = 3'd0,
        REG_REARM    = 3'd1,
        REG_DECAY    = 3'd2,
        REG_TRACK    = 3'd3,
        REG_COOLDOWN = 3'd4
    } t_reg_idx;

    localparam logic [FIELD_W-1:0] RST_TRIGGER  = 12'd400;
    localparam logic [FIELD_W-1:0] RST_REARM    = 12'd200;
    localparam logic [FIELD_W-1:0] RST_DECAY    = 12'd8;
    localparam logic [WIN_W-1:0]   RST_TRACK    = 16'd3;
    localparam logic [WIN_W-1:0]   RST_COOLDOWN = 16'd30;

    typedef struct packed {
        logic [FIELD_W-1:0] trigger_level;
        logic [FIELD_W-1:0] rearm_level;
        logic [FIELD_W-1:0] envelope_decay;
        logic [WIN_W-1:0]   track_window_ms;
        logic [WIN_W-1:0]   cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] hits;
        logic [FIELD_W-1:0] hit_peak;
        logic [FIELD_W-1:0] envelope;
    } t_lane_res;

endpackage

// File: rtl/piezo_hit_detector.sv
// ----------------------------------------------------------------------------
// piezo_hit_detector
// Per-channel piezo hit detection with peak envelope, lanes merged into
// one result per tick through a two-entry output buffer.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   i_left_sample, i_right_sample, i_now_ms
//   output    out        o_out_valid / i_out_ready o_left_*, o_right_*
//   config    in         psel/penable/pwrite       paddr, pwdata -> prdata, pready
//
// One request per cycle while o_in_ready is high; each result is registered
// in the head entry, or in the skid entry while the head is occupied.
// Synchronous active-low reset clears lane state and the output buffer.
// A skid entry keeps input flowing for one request while the output stalls;
// o_in_ready drops only when both buffer entries hold results.
// ----------------------------------------------------------------------------
module piezo_hit_detector #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned CHANNELS    = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [phd_pkg::FIELD_W-1:0]       i_left_sample,
    input  logic [phd_pkg::FIELD_W-1:0]       i_right_sample,
    input  logic [phd_pkg::TIME_W-1:0]        i_now_ms,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [phd_pkg::COUNT_W-1:0]       o_left_hits,
    output logic [phd_pkg::FIELD_W-1:0]       o_left_hit_peak,
    output logic [phd_pkg::FIELD_W-1:0]       o_left_envelope,
    output logic [phd_pkg::COUNT_W-1:0]       o_right_hits,
    output logic [phd_pkg::FIELD_W-1:0]       o_right_hit_peak,
    output logic [phd_pkg::FIELD_W-1:0]       o_right_envelope,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phd_pkg::ADDR_W-1:0]        paddr,
    input  logic [phd_pkg::DATA_W-1:0]        pwdata,
    output logic [phd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    // sample width in use never exceeds the port width
    localparam int unsigned EFF_W = (SAMPLE_BITS < phd_pkg::FIELD_W) ?
                                    SAMPLE_BITS : phd_pkg::FIELD_W;
    localparam int unsigned LANES = (CHANNELS < phd_pkg::IN_CH) ?
                                    CHANNELS : phd_pkg::IN_CH;

    phd_pkg::t_cfg                                  w_cfg;
    logic [phd_pkg::FIELD_W-1:0]                    w_sample [phd_pkg::IN_CH];
    phd_pkg::t_lane_res [phd_pkg::IN_CH-1:0]        w_res;

    logic                                           w_in_acc;
    logic                                           w_out_acc;

    logic                                           r_head_valid, n_head_valid;
    logic                                           r_skid_valid, n_skid_valid;
    phd_pkg::t_lane_res [phd_pkg::IN_CH-1:0]        r_head, n_head;
    phd_pkg::t_lane_res [phd_pkg::IN_CH-1:0]        r_skid, n_skid;

    phd_regs #(
        .W (EFF_W)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_sample[0] = i_left_sample;
    assign w_sample[1] = i_right_sample;

    assign o_in_ready = !r_skid_valid;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = r_head_valid && i_out_ready;

    for (genvar g = 0; g < phd_pkg::IN_CH; g++) begin : g_lane
        if (g < LANES) begin : g_on
            phd_lane #(
                .W (EFF_W)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_in_acc),
                .i_cfg    (w_cfg),
                .i_sample (w_sample[g]),
                .i_now_ms (i_now_ms),
                .o_res    (w_res[g])
            );
        end else begin : g_off
            assign w_res[g] = '0;
        end
    end

    // merge: lane results form one request into the head/skid buffer
    always_comb begin
        n_head_valid = r_head_valid;
        n_head       = r_head;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_out_acc) begin
            n_head_valid = r_skid_valid;
            n_head       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (w_in_acc) begin
            if (!n_head_valid) begin
                n_head_valid = 1'b1;
                n_head       = w_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_out_valid      = r_head_valid;
    assign o_left_hits      = r_head[0].hits;
    assign o_left_hit_peak  = r_head[0].hit_peak;
    assign o_left_envelope  = r_head[0].envelope;
    assign o_right_hits     = r_head[1].hits;
    assign o_right_hit_peak = r_head[1].hit_peak;
    assign o_right_envelope = r_head[1].envelope;

endmodule

// File: rtl/phd_regs.sv
// ----------------------------------------------------------------------------
// phd_regs
// APB-style register file holding levels, decay and time windows.
// ----------------------------------------------------------------------------
module phd_regs #(
    parameter int unsigned W = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phd_pkg::ADDR_W-1:0]        paddr,
    input  logic [phd_pkg::DATA_W-1:0]        pwdata,
    output logic [phd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    output phd_pkg::t_cfg                     o_cfg
);

    localparam logic [phd_pkg::FIELD_W-1:0] LVL_MASK = phd_pkg::FIELD_W'((1 << W) - 1);

    phd_pkg::t_cfg      r_cfg;
    phd_pkg::t_reg_idx  w_idx;
    logic               w_wr;

    assign w_idx  = phd_pkg::t_reg_idx'(paddr[phd_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_level   <= phd_pkg::RST_TRIGGER & LVL_MASK;
            r_cfg.rearm_level     <= phd_pkg::RST_REARM & LVL_MASK;
            r_cfg.envelope_decay  <= phd_pkg::RST_DECAY & LVL_MASK;
            r_cfg.track_window_ms <= phd_pkg::RST_TRACK;
            r_cfg.cooldown_ms     <= phd_pkg::RST_COOLDOWN;
        end else if (w_wr) begin
            case (w_idx)
                phd_pkg::REG_TRIGGER: begin
                    r_cfg.trigger_level <= pwdata[phd_pkg::FIELD_W-1:0] & LVL_MASK;
                end
                phd_pkg::REG_REARM: begin
                    r_cfg.rearm_level <= pwdata[phd_pkg::FIELD_W-1:0] & LVL_MASK;
                end
                phd_pkg::REG_DECAY: begin
                    r_cfg.envelope_decay <= pwdata[phd_pkg::FIELD_W-1:0] & LVL_MASK;
                end
                phd_pkg::REG_TRACK: begin
                    r_cfg.track_window_ms <= pwdata[phd_pkg::WIN_W-1:0];
                end
                phd_pkg::REG_COOLDOWN: begin
                    r_cfg.cooldown_ms <= pwdata[phd_pkg::WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            phd_pkg::REG_TRIGGER:  prdata = phd_pkg::DATA_W'(r_cfg.trigger_level);
            phd_pkg::REG_REARM:    prdata = phd_pkg::DATA_W'(r_cfg.rearm_level);
            phd_pkg::REG_DECAY:    prdata = phd_pkg::DATA_W'(r_cfg.envelope_decay);
            phd_pkg::REG_TRACK:    prdata = phd_pkg::DATA_W'(r_cfg.track_window_ms);
            phd_pkg::REG_COOLDOWN: prdata = phd_pkg::DATA_W'(r_cfg.cooldown_ms);
            default:               prdata = '0;
        endcase
    end

endmodule

// File: rtl/phd_lane.sv
// ----------------------------------------------------------------------------
// phd_lane
// One channel: decaying peak envelope and armed/tracking/cooldown hit machine.
// ----------------------------------------------------------------------------
module phd_lane #(
    parameter int unsigned W = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  phd_pkg::t_cfg                     i_cfg,
    input  logic [phd_pkg::FIELD_W-1:0]       i_sample,
    input  logic [phd_pkg::TIME_W-1:0]        i_now_ms,
    output phd_pkg::t_lane_res                o_res
);

    typedef enum logic [1:0] {
        PH_ARMED    = 2'd0,
        PH_TRACKING = 2'd1,
        PH_COOLDOWN = 2'd2
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [W-1:0]                   r_env, n_env;
    logic [W-1:0]                   r_peak, n_peak;
    logic [W-1:0]                   r_latched, n_latched;
    logic [phd_pkg::TIME_W-1:0]     r_track_dl, n_track_dl;
    logic [phd_pkg::TIME_W-1:0]     r_cool_dl, n_cool_dl;
    logic [phd_pkg::COUNT_W-1:0]    r_hits, n_hits;

    logic [W-1:0]                   w_sample;
    logic [W-1:0]                   w_decay;
    logic [W-1:0]                   w_dec;
    logic [phd_pkg::TIME_W-1:0]     w_track_diff;
    logic [phd_pkg::TIME_W-1:0]     w_cool_diff;

    assign w_sample     = i_sample[W-1:0];
    assign w_decay      = i_cfg.envelope_decay[W-1:0];
    assign w_dec        = (r_env > w_decay) ? (r_env - w_decay) : '0;
    // deadline reached when the wrapping difference is non-negative
    assign w_track_diff = i_now_ms - r_track_dl;
    assign w_cool_diff  = i_now_ms - r_cool_dl;

    always_comb begin
        n_env      = (w_sample > w_dec) ? w_sample : w_dec;
        n_phase    = r_phase;
        n_peak     = r_peak;
        n_latched  = r_latched;
        n_track_dl = r_track_dl;
        n_cool_dl  = r_cool_dl;
        n_hits     = r_hits;
        case (r_phase)
            PH_TRACKING: begin
                if (w_sample > r_peak) begin
                    n_peak = w_sample;
                end
                if (!w_track_diff[phd_pkg::TIME_W-1]) begin
                    n_hits    = r_hits + phd_pkg::COUNT_W'(1);
                    n_latched = n_peak;
                    n_phase   = PH_COOLDOWN;
                    n_cool_dl = i_now_ms + phd_pkg::TIME_W'(i_cfg.cooldown_ms);
                end
            end
            PH_COOLDOWN: begin
                if (!w_cool_diff[phd_pkg::TIME_W-1]
                        && w_sample <= i_cfg.rearm_level[W-1:0]) begin
                    n_phase = PH_ARMED;
                end
            end
            default: begin
                // armed, and the unused code behaves the same
                if (w_sample >= i_cfg.trigger_level[W-1:0]) begin
                    n_phase    = PH_TRACKING;
                    n_peak     = w_sample;
                    n_track_dl = i_now_ms + phd_pkg::TIME_W'(i_cfg.track_window_ms);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ARMED;
            r_env      <= '0;
            r_peak     <= '0;
            r_latched  <= '0;
            r_track_dl <= '0;
            r_cool_dl  <= '0;
            r_hits     <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_env      <= n_env;
            r_peak     <= n_peak;
            r_latched  <= n_latched;
            r_track_dl <= n_track_dl;
            r_cool_dl  <= n_cool_dl;
            r_hits     <= n_hits;
        end
    end

    // result reflects this request's update
    assign o_res.hits     = n_hits;
    assign o_res.hit_peak = phd_pkg::FIELD_W'(n_latched);
    assign o_res.envelope = phd_pkg::FIELD_W'(n_env);

endmodule

// File: rtl/phd_checker.sv
// ----------------------------------------------------------------------------
// phd_checker
// Port-level checks on the hit detector's request flow, bound to the top.
// ----------------------------------------------------------------------------
module phd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [phd_pkg::COUNT_W-1:0]       i_left_hits,
    input  logic [phd_pkg::FIELD_W-1:0]       i_left_envelope,
    input  logic [phd_pkg::COUNT_W-1:0]       i_right_hits,
    input  logic [phd_pkg::FIELD_W-1:0]       i_right_envelope
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left_hits)
            && $stable(i_left_envelope) && $stable(i_right_hits)
            && $stable(i_right_envelope))
        else $error("stalled result changed or vanished");

    // after every accepted request the output is valid on the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted request gave no result");

    // accepting while the output stalls fills the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_valid && !i_out_ready |=> !i_in_ready)
        else $error("buffer overfilled");

    // input back-pressure only with results pending
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

endmodule

bind piezo_hit_detector phd_checker u_phd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .i_in_ready       (o_in_ready),
    .i_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .i_left_hits      (o_left_hits),
    .i_left_envelope  (o_left_envelope),
    .i_right_hits     (o_right_hits),
    .i_right_envelope (o_right_envelope)
);
